/* rtl/core/cwg_pkg.sv */
`default_nettype none
package cwg_pkg;

  localparam int DEF_SINE_TABLE_BITS = 10;
  localparam int DEF_PERIOD_BITS     = 16;

  localparam int TIME_W   = 31;
  localparam int AMP_W    = 16;
  localparam int PER_W    = 16;
  localparam int FILL_W   = 7;
  localparam int SAMPLE_W = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [FILL_W-1:0] FILL_RESET = 7'd50;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECT_AMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_FILL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRI_AMP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRI_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SINE_AMP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SINE_PERIOD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_AMP    = 3'd7;

  // Taylor coefficients of sin(pi/2*z), Q30
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  // Q15 magnitude of sin(pi/2*z), z in Q30; evaluated at elaboration only
  function automatic logic [16:0] quarter_sine(input logic [63:0] z);
    logic [63:0] w;
    logic [63:0] p;
    logic [63:0] m;
    w = (z * z) >> 30;
    p = C9;
    p = C7 - ((p * w) >> 30);
    p = C5 - ((p * w) >> 30);
    p = C3 - ((p * w) >> 30);
    p = C1 - ((p * w) >> 30);
    m = (((p * z) >> 30) + 64'd16384) >> 15;
    return (m > 64'd32768) ? 17'd32768 : m[16:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/cwg_div_cell.sv */
`default_nettype none
// One restoring division step per lane, registered.
module cwg_div_cell #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           valid_i,
  input  wire logic [LANES-1:0][NW-1:0]       num_i,
  input  wire logic [LANES-1:0][NW-1:0]       quo_i,
  input  wire logic [LANES-1:0][DW-1:0]       rem_i,
  input  wire logic [LANES-1:0][DW-1:0]       div_i,
  output logic                                valid_o,
  output logic      [LANES-1:0][NW-1:0]       num_o,
  output logic      [LANES-1:0][NW-1:0]       quo_o,
  output logic      [LANES-1:0][DW-1:0]       rem_o
);

  logic                     valid_r;
  logic [LANES-1:0][NW-1:0] num_r, num_nxt;
  logic [LANES-1:0][NW-1:0] quo_r, quo_nxt;
  logic [LANES-1:0][DW-1:0] rem_r, rem_nxt;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial      = {rem_i[l], num_i[l][NW-1]};
    assign diff       = trial - {1'b0, div_i[l]};
    assign ge         = trial >= {1'b0, div_i[l]};
    assign rem_nxt[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign num_nxt[l] = {num_i[l][NW-2:0], 1'b0};
    assign quo_nxt[l] = {quo_i[l][NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign valid_o = valid_r;
  assign num_o   = num_r;
  assign quo_o   = quo_r;
  assign rem_o   = rem_r;

endmodule
`default_nettype wire

/* rtl/core/cwg_div_chain.sv */
`default_nettype none
// Row of NW division cells: quotient and remainder come out of the last cell.
module cwg_div_chain #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           valid_i,
  input  wire logic [LANES-1:0][NW-1:0]       num_i,
  input  wire logic [LANES-1:0][DW-1:0]       div_i,
  output logic                                valid_o,
  output logic      [LANES-1:0][NW-1:0]       quo_o,
  output logic      [LANES-1:0][DW-1:0]       rem_o
);

  logic                     v_s   [NW+1];
  logic [LANES-1:0][NW-1:0] num_s [NW+1];
  logic [LANES-1:0][NW-1:0] quo_s [NW+1];
  logic [LANES-1:0][DW-1:0] rem_s [NW+1];

  assign v_s[0]   = valid_i;
  assign num_s[0] = num_i;
  assign quo_s[0] = '0;
  assign rem_s[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    cwg_div_cell #(
      .LANES (LANES),
      .NW    (NW),
      .DW    (DW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (v_s[i]),
      .num_i   (num_s[i]),
      .quo_i   (quo_s[i]),
      .rem_i   (rem_s[i]),
      .div_i   (div_i),
      .valid_o (v_s[i+1]),
      .num_o   (num_s[i+1]),
      .quo_o   (quo_s[i+1]),
      .rem_o   (rem_s[i+1])
    );
  end

  assign valid_o = v_s[NW];
  assign quo_o   = quo_s[NW];
  assign rem_o   = rem_s[NW];

endmodule
`default_nettype wire

/* rtl/core/composite_waveform_generator.sv */
`default_nettype none
// Composite waveform generator: for each time index transaction it returns one sample, the
// sum of a rectangle, a triangle and a sine wave plus a constant step, all set through the
// configuration registers. One transaction is taken every clock cycle while no finished
// sample is held at the output. Each sample passes through two rows of division cells
// sized by PW, the period width (the smaller of PERIOD_BITS and 16): the first takes the
// time index modulo the three periods one bit per cell, the second divides the triangle
// numerator and the scaled sine phase by their periods. Write the registers only while no
// transaction is in flight.
module composite_waveform_generator #(
  parameter int SINE_TABLE_BITS = cwg_pkg::DEF_SINE_TABLE_BITS,
  parameter int PERIOD_BITS     = cwg_pkg::DEF_PERIOD_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cwg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [cwg_pkg::TIME_W-1:0]       in_time_index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [cwg_pkg::SAMPLE_W-1:0]   out_sample_value
);

  localparam int PW      = (PERIOD_BITS < cwg_pkg::PER_W) ? PERIOD_BITS : cwg_pkg::PER_W;
  localparam int NB      = 17 + PW;          // second divider: 2*|amp|*x
  localparam int RW      = PW + 7;           // rectangle duty compare width
  localparam int TB      = SINE_TABLE_BITS;
  localparam int QUARTER = 1 << (TB - 2);
  localparam int SW      = cwg_pkg::SAMPLE_W;

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic signed [15:0]               rect_amp_r, tri_amp_r, sine_amp_r, step_amp_r;
  logic [cwg_pkg::PER_W-1:0]        rect_per_r, tri_per_r, sine_per_r;
  logic [cwg_pkg::FILL_W-1:0]       fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_amp_r <= '0;
      rect_per_r <= '0;
      fill_r     <= cwg_pkg::FILL_RESET;
      tri_amp_r  <= '0;
      tri_per_r  <= '0;
      sine_amp_r <= '0;
      sine_per_r <= '0;
      step_amp_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cwg_pkg::REG_RECT_AMP:    rect_amp_r <= cfg_data;
        cwg_pkg::REG_RECT_PERIOD: rect_per_r <= cfg_data;
        cwg_pkg::REG_RECT_FILL:   fill_r     <= cfg_data[cwg_pkg::FILL_W-1:0];
        cwg_pkg::REG_TRI_AMP:     tri_amp_r  <= cfg_data;
        cwg_pkg::REG_TRI_PERIOD:  tri_per_r  <= cfg_data;
        cwg_pkg::REG_SINE_AMP:    sine_amp_r <= cfg_data;
        cwg_pkg::REG_SINE_PERIOD: sine_per_r <= cfg_data;
        cwg_pkg::REG_STEP_AMP:    step_amp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Periods are taken in their low PW bits
  logic [PW-1:0] rect_per, tri_per, sine_per;
  assign rect_per = rect_per_r[PW-1:0];
  assign tri_per  = tri_per_r[PW-1:0];
  assign sine_per = sine_per_r[PW-1:0];

  // Magnitudes of the amplitudes, 17 bits so that -32768 fits
  logic [16:0] tri_abs, sine_abs;
  assign tri_abs  = tri_amp_r[15]  ? 17'(-{tri_amp_r[15],  tri_amp_r})
                                   : {1'b0, tri_amp_r};
  assign sine_abs = sine_amp_r[15] ? 17'(-{sine_amp_r[15], sine_amp_r})
                                   : {1'b0, sine_amp_r};

  // ---------------------------------------------------------------------------------------
  // Flow control: the whole pipe advances unless a finished sample is held at the output
  // ---------------------------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------------------------
  // First row: time index modulo each period (lane 0 rectangle, 1 triangle, 2 sine)
  // ---------------------------------------------------------------------------------------
  logic [2:0][cwg_pkg::TIME_W-1:0] mod_num;
  logic [2:0][PW-1:0]              mod_div;
  logic                            mod_valid;
  logic [2:0][PW-1:0]              mod_rem;

  assign mod_num = {3{in_time_index}};
  assign mod_div = {sine_per, tri_per, rect_per};

  cwg_div_chain #(
    .LANES (3),
    .NW    (cwg_pkg::TIME_W),
    .DW    (PW)
  ) u_mod_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .num_i   (mod_num),
    .div_i   (mod_div),
    .valid_o (mod_valid),
    .quo_o   (),
    .rem_o   (mod_rem)
  );

  // ---------------------------------------------------------------------------------------
  // Stage B: rectangle level, triangle numerator, sine phase numerator
  // ---------------------------------------------------------------------------------------
  logic [PW-1:0] r_rect, r_tri, r_sine;
  assign r_rect = mod_rem[0];
  assign r_tri  = mod_rem[1];
  assign r_sine = mod_rem[2];

  logic        rect_on;
  logic [15:0] rect_lvl;
  assign rect_on  = (RW'(r_rect) * RW'(7'd100)) < (RW'(fill_r) * RW'(rect_per));
  assign rect_lvl = rect_on ? rect_amp_r : '0;

  // Rising half uses r, falling half period - r; r of zero lands in the rising half
  logic [PW-1:0] tri_x;
  logic [16:0]   tri_dbl;
  assign tri_x   = ({r_tri, 1'b0} < {1'b0, tri_per}) ? r_tri : tri_per - r_tri;
  assign tri_dbl = {tri_abs[15:0], 1'b0};

  logic          b_valid_r;
  logic [NB-1:0] b_tri_num_r;
  logic [NB-1:0] b_sine_num_r;
  logic [15:0]   rect_dly_r [NB+1];   // rectangle level waits out the second row

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= mod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_tri_num_r   <= NB'(tri_dbl) * NB'(tri_x);
      b_sine_num_r  <= NB'({r_sine, {TB{1'b0}}});
      rect_dly_r[0] <= rect_lvl;
      for (int i = 1; i <= NB; i++) begin
        rect_dly_r[i] <= rect_dly_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Second row: triangle magnitude and sine table index (lane 0 triangle, 1 sine)
  // ---------------------------------------------------------------------------------------
  logic [1:0][NB-1:0] dv_num;
  logic [1:0][PW-1:0] dv_div;
  logic               dv_valid;
  logic [1:0][NB-1:0] dv_quo;

  assign dv_num = {b_sine_num_r, b_tri_num_r};
  assign dv_div = {sine_per, tri_per};

  cwg_div_chain #(
    .LANES (2),
    .NW    (NB),
    .DW    (PW)
  ) u_wave_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (b_valid_r),
    .num_i   (dv_num),
    .div_i   (dv_div),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .rem_o   ()
  );

  // ---------------------------------------------------------------------------------------
  // Stage C: sign the triangle, fold the sine index into a quarter turn and look it up
  // ---------------------------------------------------------------------------------------
  logic [16:0] sine_tbl [QUARTER+1];
  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_tbl
    assign sine_tbl[gi] = cwg_pkg::quarter_sine(64'(gi) << (32 - TB));
  end

  logic [16:0]   tri_mag;
  logic [TB-1:0] sine_k;
  logic [1:0]    sine_q;
  logic [TB-3:0] sine_j;
  logic [TB-2:0] sine_off;
  assign tri_mag  = dv_quo[0][16:0];
  assign sine_k   = dv_quo[1][TB-1:0];
  assign sine_q   = sine_k[TB-1:TB-2];
  assign sine_j   = sine_k[TB-3:0];
  assign sine_off = sine_q[0] ? (TB-1)'(QUARTER) - (TB-1)'(sine_j) : (TB-1)'(sine_j);

  logic                 c_valid_r;
  logic signed [SW-1:0] c_tri_r;
  logic [16:0]          c_sine_mag_r;
  logic                 c_sine_neg_r;
  logic [15:0]          c_rect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_tri_r      <= tri_amp_r[15] ? -$signed({1'b0, tri_mag}) : $signed({1'b0, tri_mag});
      c_sine_mag_r <= sine_tbl[sine_off];
      c_sine_neg_r <= sine_q[1] ^ sine_amp_r[15];
      c_rect_r     <= rect_dly_r[NB];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage D: scale the sine by its amplitude, round half up
  // ---------------------------------------------------------------------------------------
  logic [33:0] sine_prod;
  logic [16:0] sine_val;
  assign sine_prod = 34'(sine_abs) * 34'(c_sine_mag_r) + 34'd16384;
  assign sine_val  = sine_prod[31:15];

  logic                 d_valid_r;
  logic signed [SW-1:0] d_sine_r;
  logic signed [SW-1:0] d_tri_r;
  logic [15:0]          d_rect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sine_r <= c_sine_neg_r ? -$signed({1'b0, sine_val}) : $signed({1'b0, sine_val});
      d_tri_r  <= c_tri_r;
      d_rect_r <= c_rect_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage E: drop waves with a zero period and sum into the output register
  // ---------------------------------------------------------------------------------------
  logic signed [SW-1:0] e_rect, e_tri, e_sine, e_step;
  logic signed [SW-1:0] sample_nxt;
  logic signed [SW-1:0] sample_r;

  assign e_rect = (rect_per == '0) ? '0 : SW'($signed(d_rect_r));
  assign e_tri  = (tri_per  == '0) ? '0 : d_tri_r;
  assign e_sine = (sine_per == '0) ? '0 : d_sine_r;
  assign e_step = SW'(step_amp_r);
  assign sample_nxt = e_rect + e_tri + e_sine + e_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = sample_r;

endmodule
`default_nettype wire
